/* src/imc_pkg.sv */
// ----------------------------------------------------------------------------
// imc_pkg
// Shared widths and the request and result types for the integer median counter.
// ----------------------------------------------------------------------------
package imc_pkg;

   localparam int SIDE_BITS_DEFAULT = 31;
   localparam int SIDE_W            = 31;   // port width of each side field

   typedef struct packed {
      logic       not_triangle;
      logic [1:0] median_count;
      logic       median_a_integral;
      logic       median_b_integral;
      logic       median_c_integral;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0] side_a;
      logic [SIDE_W-1:0] side_b;
      logic [SIDE_W-1:0] side_c;
   } req_type;

endpackage

/* src/imc_if.sv */
// ----------------------------------------------------------------------------
// imc_req_if / imc_rsp_if
// Valid/ready channels for side triples and median results.
// ----------------------------------------------------------------------------
interface imc_req_if;
   logic              valid;
   logic              ready;
   imc_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface imc_rsp_if;
   logic              valid;
   logic              ready;
   imc_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/imc_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// imc_sqrt_stage
// One registered stage of a restoring square root: resolves STEPS result
// bits per stage for three lanes, then holds the stage under stall.
// ----------------------------------------------------------------------------
module imc_sqrt_stage #(
   parameter int QW    = 62,
   parameter int STEPS = 4,
   parameter int FIRST = 0     // index of first result bit handled, from MSB
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [2:0][QW-1:0] in_rem,
   input  logic [2:0][QW-1:0] in_root,
   input  logic [2:0]         in_ok,
   input  logic               in_nt,
   output logic               out_valid,
   output logic [2:0][QW-1:0] out_rem,
   output logic [2:0][QW-1:0] out_root,
   output logic [2:0]         out_ok,
   output logic               out_nt
);
   localparam int RW = QW / 2;

   logic [2:0][QW-1:0] rem_in, root_in;
   logic               valid_ff;
   logic [2:0][QW-1:0] rem_ff, root_ff;
   logic [2:0]         ok_ff;
   logic               nt_ff;

   // root holds the bits found so far; setting bit k adds (4*root+1) << 2k
   // to the square, so that is the trial taken off the remainder.
   always_comb begin
      logic [QW+1:0] trial;
      int            k;
      rem_in  = in_rem;
      root_in = in_root;
      for (int l = 0; l < 3; l++) begin
         for (int s = 0; s < STEPS; s++) begin
            k = RW - 1 - FIRST - s;
            if (k >= 0) begin
               trial = ({2'b00, root_in[l]} << 2 | (QW+2)'(1)) << (2 * k);
               if ({2'b00, rem_in[l]} >= trial) begin
                  rem_in[l]  = rem_in[l] - trial[QW-1:0];
                  root_in[l] = (root_in[l] << 1) | QW'(1);
               end else begin
                  root_in[l] = root_in[l] << 1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         ok_ff   <= in_ok;
         nt_ff   <= in_nt;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_ok    = ok_ff;
   assign out_nt    = nt_ff;
endmodule

/* src/imc_front.sv */
// ----------------------------------------------------------------------------
// imc_front
// Squares, triangle test and the three d values, over three stages.
// ----------------------------------------------------------------------------
module imc_front #(
   parameter int SIDE_BITS = imc_pkg::SIDE_BITS_DEFAULT,
   parameter int QW        = 2 * SIDE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  imc_pkg::req_type            in_data,
   output logic                        out_valid,
   output logic [2:0][QW-1:0]          out_q,
   output logic [2:0]                  out_ok,
   output logic                        out_nt
);
   localparam int SW = SIDE_BITS;
   localparam int PW = 2 * SW;      // square width
   localparam int DW = PW + 3;      // 2y^2+2z^2 width

   // stage 1: mask and triangle test
   logic [SW-1:0] a_ff, b_ff, c_ff;
   logic          v1_ff, nt1_ff;
   logic [SW-1:0] a_in, b_in, c_in;
   logic          nt1_in;

   assign a_in = in_data.side_a[SW-1:0];
   assign b_in = in_data.side_b[SW-1:0];
   assign c_in = in_data.side_c[SW-1:0];
   assign nt1_in = ({1'b0, a_in} + {1'b0, b_in} <= {1'b0, c_in}) ||
                   ({1'b0, a_in} + {1'b0, c_in} <= {1'b0, b_in}) ||
                   ({1'b0, b_in} + {1'b0, c_in} <= {1'b0, a_in});

   // stage 2: squares
   logic [PW-1:0] aa_ff, bb_ff, cc_ff;
   logic          v2_ff, nt2_ff;

   // stage 3: d values, low-bit test
   logic [2:0][QW-1:0] q_ff;
   logic [2:0]         ok_ff;
   logic               v3_ff, nt3_ff;
   logic [DW-1:0]      da, db, dc, sa, sb, sc;
   logic [2:0]         ok_in;

   always_comb begin
      sa = ({3'b0, bb_ff} << 1) + ({3'b0, cc_ff} << 1);
      sb = ({3'b0, aa_ff} << 1) + ({3'b0, cc_ff} << 1);
      sc = ({3'b0, aa_ff} << 1) + ({3'b0, bb_ff} << 1);
      da = sa - {3'b0, aa_ff};
      db = sb - {3'b0, bb_ff};
      dc = sc - {3'b0, cc_ff};
      ok_in[0] = (sa > {3'b0, aa_ff}) && (da[1:0] == 2'b00);
      ok_in[1] = (sb > {3'b0, bb_ff}) && (db[1:0] == 2'b00);
      ok_in[2] = (sc > {3'b0, cc_ff}) && (dc[1:0] == 2'b00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         nt1_ff  <= nt1_in;
         aa_ff   <= a_ff * a_ff;
         bb_ff   <= b_ff * b_ff;
         cc_ff   <= c_ff * c_ff;
         nt2_ff  <= nt1_ff;
         // d/4 < 2^(2*SW) since d < 4*2^(2SW)
         q_ff[0] <= da[PW+1:2];
         q_ff[1] <= db[PW+1:2];
         q_ff[2] <= dc[PW+1:2];
         ok_ff   <= ok_in;
         nt3_ff  <= nt2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_q     = q_ff;
   assign out_ok    = ok_ff;
   assign out_nt    = nt3_ff;
endmodule

/* src/integer_median_counter_unit.sv */
// ----------------------------------------------------------------------------
// integer_median_counter_unit
// Counts the integral medians of a triangle given by three side lengths.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per handshake carries side_a, side_b, side_c.
//   rsp channel: one item per request, in order: not_triangle, median_count
//   and a flag per side.
//   Pipeline: 3 front stages (mask/triangle test, squares, d and d/4),
//   ceil(SIDE_BITS/4) square root stages (4 root bits each, three lanes),
//   and one output register.
//   Throughput: one item per cycle while the output is not stalled; every stage is a register with valid.
//   Stall: the whole pipe advances when the output register is empty or
//   taken; otherwise it holds, so nothing is lost or repeated. req_ready
//   is that advance signal and stays high while the output slot drains.
//   Reset: synchronous; clears all valid bits, the pipe comes up empty.
// ----------------------------------------------------------------------------
module integer_median_counter_unit #(
   parameter int SIDE_BITS = imc_pkg::SIDE_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   imc_req_if.sink   req,
   imc_rsp_if.source rsp
);
   localparam int QW     = 2 * SIDE_BITS;
   localparam int RW     = SIDE_BITS;
   localparam int STEPS  = 4;
   localparam int NSTAGE = (RW + STEPS - 1) / STEPS;

   logic adv;
   logic out_valid_ff;
   imc_pkg::rsp_type out_ff;

   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   logic [NSTAGE:0]              sv;
   logic [NSTAGE:0][2:0][QW-1:0] srem, sroot;
   logic [NSTAGE:0][2:0]         sok;
   logic [NSTAGE:0]              snt;

   imc_front #(.SIDE_BITS(SIDE_BITS), .QW(QW)) u_front (
      .clock, .reset, .adv,
      .in_valid (req.valid),
      .in_data  (req.data),
      .out_valid(sv[0]),
      .out_q    (srem[0]),
      .out_ok   (sok[0]),
      .out_nt   (snt[0])
   );
   assign sroot[0] = '0;

   for (genvar g = 0; g < NSTAGE; g++) begin : g_root
      imc_sqrt_stage #(.QW(QW), .STEPS(STEPS), .FIRST(g * STEPS)) u_stage (
         .clock, .reset, .adv,
         .in_valid (sv[g]),
         .in_rem   (srem[g]),
         .in_root  (sroot[g]),
         .in_ok    (sok[g]),
         .in_nt    (snt[g]),
         .out_valid(sv[g+1]),
         .out_rem  (srem[g+1]),
         .out_root (sroot[g+1]),
         .out_ok   (sok[g+1]),
         .out_nt   (snt[g+1])
      );
   end

   // exact square when remainder is zero
   logic [2:0]       whole;
   imc_pkg::rsp_type out_in;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         whole[l] = sok[NSTAGE][l] && (srem[NSTAGE][l] == '0) && !snt[NSTAGE];
      end
      out_in.not_triangle      = snt[NSTAGE];
      out_in.median_a_integral = whole[0];
      out_in.median_b_integral = whole[1];
      out_in.median_c_integral = whole[2];
      out_in.median_count      = {1'b0, whole[0]} + {1'b0, whole[1]} + {1'b0, whole[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sv[NSTAGE];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule
